// ===== hw/rtl/pipt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

  // Vertex store geometry
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned ADDR_W       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);

  // Field and datapath widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned VCOUNT_W = 7;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic                 inside_res;
    logic [VCOUNT_W-1:0]  vertex_count;
    logic                 store_full;
  } out_item_t;

  // One store entry: y in the upper half, x in the lower half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

endpackage

`default_nettype wire

// ===== hw/rtl/point_in_polygon_crossing_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Even-odd point-in-polygon test over a stored vertex list.
// Input: an item (append vertex, clear polygon, query point) is taken on a
// rising edge with start high and busy low. Output: one result item per input
// item, shown on result_o for exactly one cycle while done_o is high; the
// receiver cannot stall, so results are never held back.
// Append, clear and the unused code: result in the cycle after the item is
// taken, and busy stays low, so such items can be given every cycle.
// Query of a polygon with N stored vertices: busy while the sequencer reads
// the N vertices, replays vertex 0 and drains the edge datapath; result in
// the first cycle with busy low (an empty store answers in the cycle after
// the item is taken). The pace is set by the single read port of the vertex
// memory, which yields one vertex per cycle, followed by a three-stage edge
// datapath (differences, two 17x17 products, compare).
// Reset clears the vertex count, the sequencer and the result strobe; store
// contents are undefined until written and only written entries are read.

module point_in_polygon_crossing_test_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire pipt_pkg::in_item_t   item_i,
  output logic                      done_o,
  output pipt_pkg::out_item_t       result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN
  } state_e;

  state_e                          state_q, state_d;
  logic [pipt_pkg::CNT_W-1:0]      count_q, count_d;
  logic [pipt_pkg::CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic                            rd_vld_q, rd_vld_d;
  logic                            rd_first_q, rd_first_d;
  logic                            close_q, close_d;
  logic                            e1_vld_q, e1_vld_d;
  logic                            e2_vld_q;
  logic                            odd_q, odd_d;
  logic                            done_q, done_d;
  pipt_pkg::out_item_t             res_q, res_d;

  logic                            accept;
  logic                            mem_we, mem_re;

  pipt_pkg::vertex_t               mem [pipt_pkg::MAX_VERTICES];
  pipt_pkg::vertex_t               rdata_q;

  logic signed [pipt_pkg::COORD_W-1:0] px_q, py_q;
  pipt_pkg::vertex_t               prev_q, v0_q;

  // Vertex stream feeding the edge datapath
  logic                            s_vld, s_first;
  pipt_pkg::vertex_t               s_vert;

  // Edge stage 1: differences
  logic signed [pipt_pkg::DIFF_W-1:0] a_c, dy_c, b_c, dx_c;
  logic                            straddle_c;
  logic signed [pipt_pkg::DIFF_W-1:0] e1_a_q, e1_dy_q, e1_b_q, e1_dx_q;
  logic                            e1_straddle_q, e1_dy_pos_q;

  // Edge stage 2: products
  logic signed [pipt_pkg::PROD_W-1:0] e2_lhs_q, e2_rhs_q;
  logic                            e2_straddle_q, e2_dy_pos_q;
  logic                            hit;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign s_vld   = rd_vld_q || close_q;
  assign s_first = rd_vld_q && rd_first_q;
  assign s_vert  = close_q ? v0_q : rdata_q;

  assign straddle_c = (prev_q.y > py_q) != (s_vert.y > py_q);
  assign a_c  = pipt_pkg::DIFF_W'(px_q) - pipt_pkg::DIFF_W'(prev_q.x);
  assign b_c  = pipt_pkg::DIFF_W'(py_q) - pipt_pkg::DIFF_W'(prev_q.y);
  assign dy_c = pipt_pkg::DIFF_W'(s_vert.y) - pipt_pkg::DIFF_W'(prev_q.y);
  assign dx_c = pipt_pkg::DIFF_W'(s_vert.x) - pipt_pkg::DIFF_W'(prev_q.x);

  assign hit = e2_straddle_q &&
               (e2_dy_pos_q ? (e2_lhs_q < e2_rhs_q) : (e2_lhs_q > e2_rhs_q));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    close_d    = 1'b0;
    e1_vld_d   = s_vld && !s_first;
    odd_d      = odd_q ^ (e2_vld_q && hit);
    done_d     = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.inside_res = 1'b0;
          res_d.store_full = 1'b0;
          case (item_i.operation)
            pipt_pkg::OP_APPEND: begin
              done_d = 1'b1;
              if (count_q < pipt_pkg::CNT_W'(pipt_pkg::MAX_VERTICES)) begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                res_d.store_full = 1'b1;
              end
            end
            pipt_pkg::OP_CLEAR: begin
              done_d  = 1'b1;
              count_d = '0;
            end
            pipt_pkg::OP_QUERY: begin
              odd_d    = 1'b0;
              rd_idx_d = '0;
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
          res_d.vertex_count = pipt_pkg::VCOUNT_W'(count_d);
        end
      end
      S_READ: begin
        if (rd_idx_q != count_q) begin
          mem_re     = 1'b1;
          rd_vld_d   = 1'b1;
          rd_first_d = (rd_idx_q == '0);
          rd_idx_d   = rd_idx_q + 1'b1;
        end else begin
          // replay vertex 0 to close the polygon
          close_d = 1'b1;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(rd_vld_q || close_q || e1_vld_q || e2_vld_q)) begin
          done_d           = 1'b1;
          res_d.inside_res = odd_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      close_q    <= 1'b0;
      e1_vld_q   <= 1'b0;
      e2_vld_q   <= 1'b0;
      odd_q      <= 1'b0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      rd_vld_q   <= rd_vld_d;
      rd_first_q <= rd_first_d;
      close_q    <= close_d;
      e1_vld_q   <= e1_vld_d;
      e2_vld_q   <= e1_vld_q;
      odd_q      <= odd_d;
      done_q     <= done_d;
      res_q      <= res_d;
    end
  end

  // Vertex memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[pipt_pkg::ADDR_W-1:0]] <= '{y: item_i.coord_y, x: item_i.coord_x};
    end
    if (mem_re) begin
      rdata_q <= mem[rd_idx_q[pipt_pkg::ADDR_W-1:0]];
    end
  end

  // Edge datapath
  always_ff @(posedge clk_i) begin
    if (accept && (item_i.operation == pipt_pkg::OP_QUERY)) begin
      px_q <= item_i.coord_x;
      py_q <= item_i.coord_y;
    end
    if (s_vld) begin
      prev_q <= s_vert;
    end
    if (s_first) begin
      v0_q <= s_vert;
    end
    e1_a_q        <= a_c;
    e1_b_q        <= b_c;
    e1_dy_q       <= dy_c;
    e1_dx_q       <= dx_c;
    e1_straddle_q <= straddle_c;
    e1_dy_pos_q   <= !dy_c[pipt_pkg::DIFF_W-1];
    e2_lhs_q      <= pipt_pkg::PROD_W'(e1_a_q) * pipt_pkg::PROD_W'(e1_dy_q);
    e2_rhs_q      <= pipt_pkg::PROD_W'(e1_b_q) * pipt_pkg::PROD_W'(e1_dx_q);
    e2_straddle_q <= e1_straddle_q;
    e2_dy_pos_q   <= e1_dy_pos_q;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pipt_pkg::CNT_W'(pipt_pkg::MAX_VERTICES))
    else $error("vertex count above store depth");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.store_full) |->
      (count_q == pipt_pkg::CNT_W'(pipt_pkg::MAX_VERTICES)))
    else $error("append refused while store not full");

  a_short_op_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.operation != pipt_pkg::OP_QUERY)) |=> done_o)
    else $error("non-query item without result in next cycle");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rd_idx_q <= count_q))
    else $error("read index past stored vertices");

endmodule

`default_nettype wire
